[rtl/dtpa_pkg.sv]
// Package with constants, types and state codes of the debounced tachometer.
`default_nettype none

package dtpa_pkg;

  // Depth of the period history; valid range 1 to 255.
  localparam int HISTORY_DEPTH = 8;

  // Field widths.
  localparam int TIME_W   = 16;
  localparam int MAGNET_W = 8;

  // Derived widths of the history memory and the averaging datapath.
  localparam int AW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = TIME_W + CNT_W;
  localparam int DV_W   = MAGNET_W;
  localparam int STEP_W = $clog2(SUM_W + 1);

  // Register reset values.
  localparam logic [TIME_W-1:0]   DEBOUNCE_RESET   = TIME_W'(50);
  localparam logic [TIME_W-1:0]   MAX_PERIOD_RESET = TIME_W'(4000);
  localparam logic [MAGNET_W-1:0] MAGNET_RESET     = MAGNET_W'(1);

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_MAX_PERIOD = 2'd1,
    REG_MAGNET     = 2'd2,
    REG_NONE       = 2'd3
  } reg_index_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_LOAD1,
    ST_DIV1,
    ST_LOAD2,
    ST_DIV2,
    ST_FINISH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              pin_level;
  } in_t;

  typedef struct packed {
    logic              accepted;
    logic [TIME_W-1:0] last_period;
    logic [TIME_W-1:0] average_period;
  } out_t;

endpackage

`default_nettype wire

[rtl/debounced_tachometer_period_average_top.sv]
// Top level of the debounced tachometer with a filtered period average.
`default_nettype none

// Each edge transaction yields one result transaction. An edge is taken when
// the pin is high and the time since the last taken edge (modulo 2^16) is at
// least debounce_ms; its period is written into a circular history memory.
// The result carries the take flag, the newest period and the average of the
// history entries that are nonzero and below max_period, divided by their
// count and then by magnet_count (0 is treated as 1), or 0 if no entry
// qualifies or the average exceeds max_period. A transaction makes one memory
// read per history entry to form the sum, then two divisions on one shared
// restoring divider that resolves one quotient bit per cycle. When no entry
// qualifies the divisions are skipped. A result still held in the output
// register stalls the block in its done state. A new edge is taken only
// while the block is idle, but the finished result waits in an output
// register so the next edge can start before it is taken. Entries never
// written since reset are left out of the average through per-entry valid
// bits, so no clearing pass is needed.
module debounced_tachometer_period_average_top (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire dtpa_pkg::in_t         in_data,
  output logic                       out_valid,
  input  wire                        out_ready,
  output dtpa_pkg::out_t             out_data,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [dtpa_pkg::PADDR_W-1:0] paddr,
  input  wire [dtpa_pkg::PDATA_W-1:0] pwdata,
  output logic [dtpa_pkg::PDATA_W-1:0] prdata,
  output logic                       pready
);
  import dtpa_pkg::*;

  // Configuration registers.
  logic [TIME_W-1:0]   debounce_ms;
  logic [TIME_W-1:0]   max_period;
  logic [MAGNET_W-1:0] magnet_count;
  reg_index_t          reg_sel;
  logic                cfg_write;

  // History memory and its bookkeeping.
  logic [TIME_W-1:0]        hist_mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] hist_valid;
  logic [AW-1:0]            wr_ptr;
  logic [TIME_W-1:0]        rd_data;
  logic                     rd_data_valid;
  logic                     rd_pend;
  logic [CNT_W-1:0]         rd_cnt;

  // Per-transaction state.
  state_t            state;
  state_t            state_next;
  logic [TIME_W-1:0] last_edge_time;
  logic [TIME_W-1:0] last_period;
  logic              take_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  count_r;
  logic [TIME_W-1:0] avg_r;

  // Shared divider.
  logic [SUM_W-1:0]  dvd;
  logic [DV_W-1:0]   rem;
  logic [DV_W-1:0]   dsr;
  logic [STEP_W-1:0] div_step;
  logic [DV_W:0]     rem_shift;
  logic              q_bit;
  logic              div_last;

  // Handshake and control strobes.
  logic              in_fire;
  logic [TIME_W-1:0] delta;
  logic              take;
  logic              rd_issue;
  logic              out_load;
  logic              qualify;

  // Configuration port: writes on the access phase, reads combinational.
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms  <= DEBOUNCE_RESET;
      max_period   <= MAX_PERIOD_RESET;
      magnet_count <= MAGNET_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_DEBOUNCE:   debounce_ms  <= pwdata[TIME_W-1:0];
        REG_MAX_PERIOD: max_period   <= pwdata[TIME_W-1:0];
        REG_MAGNET:     magnet_count <= pwdata[MAGNET_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DEBOUNCE:   prdata = PDATA_W'(debounce_ms);
      REG_MAX_PERIOD: prdata = PDATA_W'(max_period);
      REG_MAGNET:     prdata = PDATA_W'(magnet_count);
      default:        prdata = '0;
    endcase
  end

  // Edge qualification.
  assign in_fire = in_valid & in_ready;
  assign delta   = in_data.now_ms - last_edge_time;
  assign take    = in_data.pin_level & (delta >= debounce_ms);

  // Divider step: shift one dividend bit into the remainder and try to subtract.
  assign rem_shift = {rem, dvd[SUM_W-1]};
  assign q_bit     = (rem_shift >= {1'b0, dsr});
  assign div_last  = (div_step == STEP_W'(SUM_W - 1));

  // A history entry counts if it was written, is nonzero and below max_period.
  assign qualify = rd_data_valid & (rd_data != '0) & (rd_data < max_period);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_fire) state_next = ST_SUM;
      ST_SUM:    if (rd_cnt == CNT_W'(HISTORY_DEPTH)) state_next = ST_LOAD1;
      ST_LOAD1:  state_next = (count_r == '0) ? ST_DONE : ST_DIV1;
      ST_DIV1:   if (div_last) state_next = ST_LOAD2;
      ST_LOAD2:  state_next = ST_DIV2;
      ST_DIV2:   if (div_last) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_DONE;
      ST_DONE:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    rd_issue = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SUM:  rd_issue = (rd_cnt != CNT_W'(HISTORY_DEPTH));
      ST_DONE: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (in_fire && take) hist_mem[wr_ptr] <= delta;
    if (rd_issue) rd_data <= hist_mem[rd_cnt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid     <= '0;
      wr_ptr         <= '0;
      last_edge_time <= '0;
      last_period    <= '0;
      rd_pend        <= 1'b0;
    end else begin
      if (in_fire && take) begin
        hist_valid[wr_ptr] <= 1'b1;
        wr_ptr <= (wr_ptr == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        last_edge_time <= in_data.now_ms;
        last_period    <= delta;
      end
      rd_pend <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) rd_data_valid <= hist_valid[rd_cnt[AW-1:0]];
  end

  // Sum and count pass, then the two divisions and the range check.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        take_r  <= take;
        rd_cnt  <= '0;
        sum_r   <= '0;
        count_r <= '0;
      end
      ST_SUM: begin
        if (rd_issue) rd_cnt <= rd_cnt + 1'b1;
        if (rd_pend && qualify) begin
          sum_r   <= sum_r + SUM_W'(rd_data);
          count_r <= count_r + 1'b1;
        end
      end
      ST_LOAD1: begin
        avg_r    <= '0;
        dvd      <= sum_r;
        dsr      <= DV_W'(count_r);
        rem      <= '0;
        div_step <= '0;
      end
      ST_DIV1, ST_DIV2: begin
        rem      <= q_bit ? DV_W'(rem_shift - {1'b0, dsr}) : rem_shift[DV_W-1:0];
        dvd      <= {dvd[SUM_W-2:0], q_bit};
        div_step <= div_step + 1'b1;
      end
      ST_LOAD2: begin
        dsr      <= (magnet_count == '0) ? DV_W'(1) : magnet_count;
        rem      <= '0;
        div_step <= '0;
      end
      ST_FINISH: begin
        avg_r <= (dvd > SUM_W'(max_period)) ? '0 : dvd[TIME_W-1:0];
      end
      default: ;
    endcase
  end

  // Output register decouples the result from the next transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.accepted       <= take_r;
      out_data.last_period    <= last_period;
      out_data.average_period <= avg_r;
    end
  end

endmodule

`default_nettype wire

[rtl/dtpa_checker.sv]
// Port-level checker for the debounced tachometer and its bind statement.
`default_nettype none

module dtpa_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire dtpa_pkg::out_t out_data,
  input wire                 pready
);
  import dtpa_pkg::*;

  // After reset the block is empty and ready for an edge.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // An accepted edge keeps the input closed for at least the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second edge taken while one is in progress");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A result appears only after an edge was taken, never right behind it.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared in the cycle after the edge");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind debounced_tachometer_period_average_top dtpa_checker u_dtpa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);

`default_nettype wire
